/* rtl/positional_sequence_store_macros.svh */
// Assertion macros for the positional sequence store checker.
// Needs clk and rst visible at the point of use.
`ifndef POSITIONAL_SEQUENCE_STORE_MACROS_SVH
`define POSITIONAL_SEQUENCE_STORE_MACROS_SVH

// checked outside reset
`define PSS_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PSS_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pss_pkg.sv */
// Shared types and constants for the positional sequence store.
// No dependencies.
package pss_pkg;

  localparam int PSS_CAPACITY = 16;
  localparam int DATA_W       = 32;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_POS   = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;
  localparam logic [2:0] OP_DUMP      = 3'd5;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT,
    CELL_FROM_HEAD
  } cell_act_t;

endpackage

/* rtl/positional_sequence_store.sv */
// Top level of the positional sequence store: sequencer plus a row of cells.
// Depends on pss_pkg, pss_ctrl and pss_cell.
//
// Command-style store of up to CAPACITY signed 32-bit values, front to back.
// An operation is taken when start is high and busy is low. Inserts, deletes
// and unused op codes give one result in the next cycle, so a new operation
// may follow every cycle. A dump of n entries holds busy while the cell row
// rotates once around its occupied part, giving one result per cycle; the row
// is back in order when busy drops. Every result shows for exactly one cycle
// with strobe high and cannot be held off, so the
// receiver must take it in that cycle.
module positional_sequence_store import pss_pkg::*; #(
  parameter int CAPACITY = PSS_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               op,
  input  logic signed [DATA_W-1:0] value,
  input  logic [7:0]               position,
  output logic                     strobe,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] value_out,
  output logic [4:0]               count,
  output logic                     last
);

  logic [DATA_W-1:0] q [CAPACITY];
  cell_act_t         act [CAPACITY];
  logic [DATA_W-1:0] load_val;
  logic [DATA_W-1:0] value_out_u;

  pss_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .value     (value),
    .position  (position),
    .q         (q),
    .act       (act),
    .load_val  (load_val),
    .strobe    (strobe),
    .status    (status),
    .value_out (value_out_u),
    .count     (count),
    .last      (last)
  );

  assign value_out = value_out_u;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pss_cell u_cell (
      .clk      (clk),
      .act      (act[i]),
      .load_val (load_val),
      .prev_val ((i == 0) ? load_val : q[(i == 0) ? 0 : i - 1]),
      .next_val ((i == CAPACITY - 1) ? q[i] : q[(i == CAPACITY - 1) ? i : i + 1]),
      .head_val (q[0]),
      .q        (q[i])
    );
  end

endmodule

/* rtl/pss_cell.sv */
// One storage cell of the chain: holds one entry, loads from the input value, its neighbors or the head.
// Depends on pss_pkg.
module pss_cell import pss_pkg::*; (
  input  logic              clk,
  input  cell_act_t         act,
  input  logic [DATA_W-1:0] load_val,
  input  logic [DATA_W-1:0] prev_val,
  input  logic [DATA_W-1:0] next_val,
  input  logic [DATA_W-1:0] head_val,
  output logic [DATA_W-1:0] q
);

  always_ff @(posedge clk) begin
    case (act)
      CELL_LOAD:      q <= load_val;
      CELL_FROM_PREV: q <= prev_val;
      CELL_FROM_NEXT: q <= next_val;
      CELL_FROM_HEAD: q <= head_val;
      default:        q <= q;
    endcase
  end

endmodule

/* rtl/pss_ctrl.sv */
// Sequencer of the store: decodes operations, keeps the count, steers the cells
// and registers results. Depends on pss_pkg.
module pss_ctrl import pss_pkg::*; #(
  parameter int CAPACITY = PSS_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               op,
  input  logic [DATA_W-1:0]        value,
  input  logic [7:0]               position,
  input  logic [DATA_W-1:0]        q [CAPACITY],
  output cell_act_t                act [CAPACITY],
  output logic [DATA_W-1:0]        load_val,
  output logic                     strobe,
  output logic [1:0]               status,
  output logic [DATA_W-1:0]        value_out,
  output logic [4:0]               count,
  output logic                     last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     rem, rem_next;
  logic              strobe_next;
  logic [1:0]        status_next;
  logic [DATA_W-1:0] value_next;
  logic              last_next;

  logic              accept;
  logic              full;
  logic              empty;
  logic              pos_bad;
  logic              ins_go;
  logic [CW-1:0]     ins_idx;
  logic [CW-1:0]     cnt_m1;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     cnt_p1;

  assign busy     = (state == S_DUMP);
  assign accept   = start && !busy;
  assign full     = (cnt == CW'(CAPACITY));
  assign empty    = (cnt == '0);
  assign cnt_m1   = cnt - CW'(1);
  assign pos_ext  = PW'(position);
  assign cnt_p1   = PW'(cnt) + PW'(1);
  assign pos_bad  = (pos_ext == '0) || (pos_ext > cnt_p1);
  assign load_val = value;

  always_comb begin
    ins_idx = '0;
    case (op)
      OP_INS_BACK: ins_idx = cnt;
      OP_INS_POS:  ins_idx = CW'(pos_ext - PW'(1));
      default:     ins_idx = '0;
    endcase
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    rem_next    = rem;
    strobe_next = 1'b0;
    status_next = STAT_OK;
    value_next  = '0;
    last_next   = 1'b1;
    ins_go      = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      act[i] = CELL_HOLD;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
              if (op == OP_INS_POS && pos_bad) begin
                status_next = STAT_BADPOS;
              end else if (full) begin
                status_next = STAT_FULL;
              end else begin
                ins_go   = 1'b1;
                cnt_next = cnt + CW'(1);
              end
            end
            OP_DEL_FRONT: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                value_next = q[0];
                cnt_next   = cnt_m1;
                for (int i = 0; i < CAPACITY - 1; i++) begin
                  act[i] = CELL_FROM_NEXT;
                end
              end
            end
            OP_DEL_BACK: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                value_next = q[cnt_m1[IW-1:0]];
                cnt_next   = cnt_m1;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                strobe_next = 1'b0;
                rem_next    = cnt;
                state_next  = S_DUMP;
              end
            end
            default: begin
              status_next = STAT_OK;
            end
          endcase
        end
        if (ins_go) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == ins_idx) begin
              act[i] = CELL_LOAD;
            end else if (CW'(i) > ins_idx && CW'(i) <= cnt) begin
              act[i] = CELL_FROM_PREV;
            end
          end
        end
      end
      S_DUMP: begin
        // emit the head, rotate the occupied cells by one
        strobe_next = 1'b1;
        value_next  = q[0];
        last_next   = (rem == CW'(1));
        rem_next    = rem - CW'(1);
        if (rem == CW'(1)) begin
          state_next = S_IDLE;
        end
        for (int i = 0; i < CAPACITY; i++) begin
          if (CW'(i) == cnt_m1) begin
            act[i] = CELL_FROM_HEAD;
          end else if (i < CAPACITY - 1) begin
            act[i] = CELL_FROM_NEXT;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      rem    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      rem    <= rem_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    status    <= status_next;
    value_out <= value_next;
    count     <= 5'(cnt_next);
    last      <= last_next;
  end

endmodule

/* rtl/pss_checker.sv */
// Port-level checks for the positional sequence store, bound to the top level.
// Depends on pss_pkg and positional_sequence_store_macros.svh.
`include "positional_sequence_store_macros.svh"

module pss_checker import pss_pkg::*; #(
  parameter int CAPACITY = PSS_CAPACITY
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [2:0]               op,
  input logic signed [DATA_W-1:0] value,
  input logic [7:0]               position,
  input logic                     strobe,
  input logic [1:0]               status,
  input logic signed [DATA_W-1:0] value_out,
  input logic [4:0]               count,
  input logic                     last
);

  `PSS_ASSERT_ALL(a_reset_quiet, rst |=> !strobe && !busy, "result after reset")
  `PSS_ASSERT_RUN(a_single, start && !busy && op != OP_DUMP |=> strobe && last && !busy, "single-result op did not answer next cycle")
  `PSS_ASSERT_RUN(a_dump_flow, busy |=> strobe, "dump cycle without a transfer")
  `PSS_ASSERT_RUN(a_error_clean, strobe && status != STAT_OK |-> last && value_out == 0, "error result not final or carries data")

endmodule

bind positional_sequence_store pss_checker #(.CAPACITY(CAPACITY)) u_pss_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for positional_sequence_store (command style, strobed results).
// Needs pss_pkg and the store RTL; a queue-based shadow store predicts every result.
module tb_top;
  import pss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_GUARD = 5000;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value_out;
    logic [4:0]               count;
    logic                     last;
  } store_result_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [2:0]               op;
  logic signed [DATA_W-1:0] value;
  logic [7:0]               position;
  logic                     strobe;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] value_out;
  logic [4:0]               count;
  logic                     last;

  logic signed [DATA_W-1:0] stored_vals[$];
  store_result_t            pending_results[$];
  int                       mismatches;
  int                       cycles;
  bit                       idle_on;

  positional_sequence_store u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .value     (value),
    .position  (position),
    .strobe    (strobe),
    .status    (status),
    .value_out (value_out),
    .count     (count),
    .last      (last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 60) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // shadow of the store: index 0 is the front
  function automatic void predict_op(input logic [2:0] o, input logic signed [DATA_W-1:0] v,
                                     input logic [7:0] p);
    store_result_t r;
    int n;
    n = stored_vals.size();
    r = '{status: STAT_OK, value_out: '0, count: 5'(n), last: 1'b1};
    case (o)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (n >= PSS_CAPACITY) begin
          r.status = STAT_FULL;
        end else if (o == OP_INS_FRONT) begin
          stored_vals.push_front(v);
        end else begin
          stored_vals.push_back(v);
        end
      end
      OP_INS_POS: begin
        if (int'(p) < 1 || int'(p) > n + 1) begin
          r.status = STAT_BADPOS;
        end else if (n >= PSS_CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          stored_vals.insert(int'(p) - 1, v);
        end
      end
      OP_DEL_FRONT: begin
        if (n == 0) r.status = STAT_EMPTY;
        else r.value_out = stored_vals.pop_front();
      end
      OP_DEL_BACK: begin
        if (n == 0) r.status = STAT_EMPTY;
        else r.value_out = stored_vals.pop_back();
      end
      OP_DUMP: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < n; i++) begin
            r.value_out = stored_vals[i];
            r.last = (i == n - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.count = 5'(stored_vals.size());
    pending_results.push_back(r);
  endfunction

  // check results first, then record the transfer taken at this edge
  always @(posedge clk) begin : result_monitor
    store_result_t exp_r;
    if (!rst) begin
      if (strobe) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected (status %0d value %0d)",
                                  status, value_out));
        end else begin
          exp_r = pending_results.pop_front();
          if (status !== exp_r.status)
            flag_mismatch($sformatf("status %0d, expected %0d", status, exp_r.status));
          if (value_out !== exp_r.value_out)
            flag_mismatch($sformatf("value_out %0d, expected %0d", value_out, exp_r.value_out));
          if (count !== exp_r.count)
            flag_mismatch($sformatf("count %0d, expected %0d", count, exp_r.count));
          if (last !== exp_r.last)
            flag_mismatch($sformatf("last %0b, expected %0b", last, exp_r.last));
        end
      end
      if (start && !busy) predict_op(op, value, position);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_position();
    int n;
    n = stored_vals.size();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 8'($urandom_range(n + 2, 255));
      default: return 8'($urandom_range(1, n + 1));
    endcase
  endfunction

  // call at a rising edge; returns at the edge that takes the transfer, or later when idle_on adds idle gaps
  task automatic send_op(input logic [2:0] o, input logic signed [DATA_W-1:0] v,
                         input logic [7:0] p);
    start    <= 1'b1;
    op       <= o;
    value    <= v;
    position <= p;
    do @(posedge clk); while (busy);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 24) begin
        start    <= 1'b0;
        op       <= 3'($urandom);
        value    <= $urandom;
        position <= 8'($urandom);
        @(posedge clk);
      end
    end
  endtask

  // one edge first so the transfer taken at the calling edge is recorded
  task automatic wait_results_done();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic send_random_op();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)      send_op(OP_INS_FRONT, pick_value(), 8'($urandom));
    else if (pick < 30) send_op(OP_INS_BACK, pick_value(), 8'($urandom));
    else if (pick < 45) send_op(OP_INS_POS, pick_value(), pick_position());
    else if (pick < 62) send_op(OP_DEL_FRONT, $urandom, 8'($urandom));
    else if (pick < 80) send_op(OP_DEL_BACK, $urandom, 8'($urandom));
    else if (pick < 96) send_op(OP_DUMP, $urandom, 8'($urandom));
    else if (pick < 98) send_op(OP_SPARE_6, $urandom, 8'($urandom));
    else                send_op(OP_SPARE_7, $urandom, 8'($urandom));
  endtask

  task automatic test_empty_store();
    send_op(OP_DUMP, 32'sd7, 8'd0);
    send_op(OP_DEL_FRONT, -1, 8'd255);
    send_op(OP_DEL_BACK, 32'sh80000000, 8'd1);
    send_op(OP_INS_POS, 32'sd9, 8'd0);
    send_op(OP_INS_POS, 32'sd9, 8'd2);
    send_op(OP_SPARE_6, -1, 8'd255);
    send_op(OP_SPARE_7, 32'sh7fffffff, 8'd1);
  endtask

  task automatic test_end_positions();
    send_op(OP_INS_POS, 32'sd5, 8'd1);
    send_op(OP_INS_FRONT, 32'sh7fffffff, 8'd0);
    send_op(OP_INS_BACK, 32'sh80000000, 8'd0);
    send_op(OP_INS_POS, -1, 8'd4);
    send_op(OP_INS_POS, 32'sd0, 8'd6);
    send_op(OP_INS_POS, 32'sd3, 8'd255);
    send_op(OP_INS_POS, 32'sd0, 8'd2);
    send_op(OP_DUMP, 32'sd0, 8'd0);
    send_op(OP_DEL_FRONT, 32'sd0, 8'd0);
    send_op(OP_DEL_BACK, 32'sd0, 8'd0);
    send_op(OP_SPARE_6, 32'sd0, 8'd0);
    send_op(OP_DUMP, 32'sd0, 8'd0);
  endtask

  // fill past the top, probe the full store, then empty it past the bottom
  task automatic test_fill_and_drain();
    idle_on = 1'b0;
    repeat (PSS_CAPACITY + 4) begin
      case ($urandom_range(0, 2))
        0: send_op(OP_INS_FRONT, pick_value(), 8'($urandom));
        1: send_op(OP_INS_BACK, pick_value(), 8'($urandom));
        default: send_op(OP_INS_POS, pick_value(), 8'($urandom_range(1, stored_vals.size() + 1)));
      endcase
    end
    send_op(OP_INS_POS, pick_value(), 8'd1);
    send_op(OP_INS_POS, pick_value(), 8'(PSS_CAPACITY + 1));
    send_op(OP_INS_POS, pick_value(), 8'(PSS_CAPACITY + 2));
    send_op(OP_INS_POS, pick_value(), 8'd255);
    send_op(OP_DUMP, $urandom, 8'($urandom));
    idle_on = 1'b1;
    repeat (PSS_CAPACITY + 2) begin
      if ($urandom_range(0, 1)) send_op(OP_DEL_FRONT, $urandom, 8'($urandom));
      else send_op(OP_DEL_BACK, $urandom, 8'($urandom));
    end
    send_op(OP_DUMP, $urandom, 8'($urandom));
  endtask

  task automatic test_pause_for_results();
    repeat (3) send_op(OP_INS_BACK, pick_value(), 8'($urandom));
    send_op(OP_DUMP, $urandom, 8'($urandom));
    wait_results_done();
    repeat ($urandom_range(1, 5)) @(posedge clk);
    send_op(OP_DUMP, $urandom, 8'($urandom));
    send_op(OP_INS_POS, pick_value(), 8'd2);
  endtask

  task automatic test_random_mix(input int n_items, input bit with_idle);
    idle_on = with_idle;
    repeat (n_items) send_random_op();
    idle_on = 1'b1;
  endtask

  initial begin
    mismatches = 0;
    cycles     = 0;
    idle_on    = 1'b1;
    rst      <= 1'b1;
    start    <= 1'b0;
    op       <= '0;
    value    <= '0;
    position <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_store();
    test_end_positions();
    test_fill_and_drain();
    test_pause_for_results();
    test_random_mix(120, 1'b1);
    test_random_mix(30, 1'b0);

    wait_results_done();
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/pss_pkg.sv
rtl/pss_cell.sv
rtl/pss_ctrl.sv
rtl/positional_sequence_store.sv
rtl/pss_checker.sv
tb/tb_top.sv
